### rtl/h264rtp_pkg.sv
`default_nettype none

package h264rtp_pkg;

  localparam int unsigned MAX_NAL_BYTES_DEF = 1048575;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_FRAME_RATE    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_LIMIT = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_PAYLOAD_TYPE  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SSRC          = 2'd3;

  localparam logic [10:0] PAYLOAD_LIMIT_RST = 11'd1400;
  localparam logic [6:0]  PAYLOAD_TYPE_RST  = 7'd96;
  localparam logic [31:0] SSRC_RST          = 32'd0;

  localparam logic [10:0] LIMIT_MIN = 11'd2;
  localparam logic [10:0] LIMIT_MAX = 11'd1460;

  // 90 kHz step = 90000 / frame_rate, at most 90000
  localparam int STEP_W = 17;
  localparam logic [STEP_W-1:0] TS_CLOCK    = 17'd90000;
  localparam logic [STEP_W-1:0] TS_STEP_RST = 17'd3600;

  localparam logic [7:0]  RTP_BYTE0     = 8'h80;
  localparam logic [7:0]  NAL_FNRI_MASK = 8'hE0;
  localparam logic [4:0]  FU_A_TYPE     = 5'd28;
  localparam logic [10:0] RTP_HDR_BYTES = 11'd12;
  localparam logic [10:0] FU_HDR_BYTES  = 11'd14;

  localparam int CMD_FIFO_DEPTH = 4;

  typedef struct packed {
    logic [7:0]  nal_byte;
    logic        first_of_nal;
    logic [19:0] nal_length;
  } nal_item_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        packet_start;
    logic        packet_end;
    logic [10:0] packet_length;
  } pkt_item_t;

  // one packet-building command from the classifier to the byte sequencer
  typedef struct packed {
    logic        has_hdr;
    logic        has_fu;
    logic        has_data;
    logic        marker;
    logic [15:0] seq;
    logic [31:0] ts;
    logic [10:0] plen;
    logic [7:0]  fu_ind;
    logic [7:0]  fu_hdr;
    logic [7:0]  data;
    logic        data_end;
  } cmd_t;

endpackage

`default_nettype wire

### rtl/h264_nal_rtp_packetizer_core.sv
// An accepted NAL byte is queued as a command and leaves through the registered packet port.
// Throughput: one NAL byte per cycle while the queue has room; each packet also sends 12 header bytes
// (14 for FU-A) on the single output byte lane, and the input stalls once the command queue fills.
// A frame_rate write stalls the input while the serial divider runs.
// Reset (rst, synchronous) clears counters, queue and output; registers take defaults.
`default_nettype none

module h264_nal_rtp_packetizer_core #(
  parameter int unsigned MAX_NAL_BYTES = h264rtp_pkg::MAX_NAL_BYTES_DEF
) (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    nal_valid,
  output logic                                         nal_stall,
  input  wire h264rtp_pkg::nal_item_t                  nal_item,
  output logic                                         pkt_valid,
  input  wire logic                                    pkt_stall,
  output h264rtp_pkg::pkt_item_t                       pkt_item,
  input  wire logic                                    cfg_wr_en,
  input  wire logic [h264rtp_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  wire logic [h264rtp_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import h264rtp_pkg::*;

  logic [10:0]       payload_limit;
  logic [6:0]        rtp_ptype;
  logic [31:0]       ssrc_value;
  logic              div_start;
  logic              div_busy;
  logic [STEP_W-1:0] ts_step;
  logic              take;
  logic              cmd_valid;
  cmd_t              cmd;
  logic              fifo_full;
  logic              head_valid;
  cmd_t              head;
  logic              pop;

  assign div_start = cfg_wr_en && cfg_index == REG_FRAME_RATE;
  assign nal_stall = fifo_full || div_busy;
  assign take      = nal_valid && !nal_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      payload_limit <= PAYLOAD_LIMIT_RST;
      rtp_ptype     <= PAYLOAD_TYPE_RST;
      ssrc_value    <= SSRC_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PAYLOAD_LIMIT: payload_limit <= cfg_data[10:0];
        REG_PAYLOAD_TYPE:  rtp_ptype     <= cfg_data[6:0];
        REG_SSRC:          ssrc_value    <= cfg_data;
        default:           payload_limit <= payload_limit;
      endcase
    end
  end

  h264rtp_step_div u_step_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .divisor (cfg_data[7:0]),
    .busy    (div_busy),
    .step    (ts_step)
  );

  h264rtp_front #(
    .MAX_NAL_BYTES (MAX_NAL_BYTES)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .take          (take),
    .item          (nal_item),
    .payload_limit (payload_limit),
    .ts_step       (ts_step),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd)
  );

  h264rtp_cmd_fifo u_cmd_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (take && cmd_valid),
    .push_cmd   (cmd),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head),
    .full       (fifo_full)
  );

  h264rtp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .rtp_ptype  (rtp_ptype),
    .ssrc_value (ssrc_value),
    .pkt_stall  (pkt_stall),
    .pop        (pop),
    .pkt_valid  (pkt_valid),
    .pkt_item   (pkt_item)
  );

endmodule

`default_nettype wire

### rtl/h264rtp_step_div.sv
`default_nettype none

module h264rtp_step_div (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           start,
  input  wire logic [7:0]                     divisor,
  output logic                                busy,
  output logic [h264rtp_pkg::STEP_W-1:0]      step
);
  import h264rtp_pkg::*;

  localparam int CNT_W = $clog2(STEP_W);

  logic [CNT_W-1:0]  cnt;
  logic [STEP_W-1:0] dvd;
  logic [STEP_W-1:0] quo;
  logic [7:0]        rem;
  logic [7:0]        dsr;
  logic [8:0]        trial;
  logic              ge;
  logic [7:0]        rem_next;

  assign trial    = {rem, dvd[STEP_W-1]};
  assign ge       = trial >= {1'b0, dsr};
  assign rem_next = ge ? 8'(trial - {1'b0, dsr}) : trial[7:0];

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
      step <= TS_STEP_RST;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CNT_W'(STEP_W - 1);
      dvd  <= TS_CLOCK;
      quo  <= '0;
      rem  <= '0;
      dsr  <= (divisor == 8'd0) ? 8'd1 : divisor;
    end else if (busy) begin
      rem <= rem_next;
      dvd <= {dvd[STEP_W-2:0], 1'b0};
      quo <= {quo[STEP_W-2:0], ge};
      cnt <= cnt - CNT_W'(1);
      if (cnt == '0) begin
        busy <= 1'b0;
        step <= {quo[STEP_W-2:0], ge};
      end
    end
  end

endmodule

`default_nettype wire

### rtl/h264rtp_front.sv
`default_nettype none

module h264rtp_front #(
  parameter int unsigned MAX_NAL_BYTES = h264rtp_pkg::MAX_NAL_BYTES_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          take,
  input  wire h264rtp_pkg::nal_item_t        item,
  input  wire logic [10:0]                   payload_limit,
  input  wire logic [h264rtp_pkg::STEP_W-1:0] ts_step,
  output logic                               cmd_valid,
  output h264rtp_pkg::cmd_t                  cmd
);
  import h264rtp_pkg::*;

  localparam int POS_W = $clog2(MAX_NAL_BYTES + 1);

  logic [15:0]      seq;
  logic [31:0]      timestamp;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] total;
  logic [7:0]       hdr_byte;
  logic             fragmenting;
  logic [10:0]      lim;
  logic [10:0]      frag_left;
  logic [10:0]      frag_plen;

  logic [15:0]      seq_next;
  logic [31:0]      timestamp_next;
  logic [POS_W-1:0] pos_next;
  logic [POS_W-1:0] total_next;
  logic [7:0]       hdr_byte_next;
  logic             fragmenting_next;
  logic [10:0]      lim_next;
  logic [10:0]      frag_left_next;
  logic [10:0]      frag_plen_next;

  logic [31:0]      len_wide;
  logic [POS_W-1:0] len_c;
  logic [10:0]      lim_c;
  logic [POS_W-1:0] pos_inc;
  logic [POS_W-1:0] remaining;
  logic             last_frag;
  logic [10:0]      frag_len;
  logic [7:0]       fu_ind;

  always_comb begin
    len_wide  = {12'd0, item.nal_length};
    len_c     = (len_wide > 32'(MAX_NAL_BYTES)) ? POS_W'(MAX_NAL_BYTES) : POS_W'(len_wide);
    if (payload_limit < LIMIT_MIN) begin
      lim_c = LIMIT_MIN;
    end else if (payload_limit > LIMIT_MAX) begin
      lim_c = LIMIT_MAX;
    end else begin
      lim_c = payload_limit;
    end
    pos_inc   = pos + POS_W'(1);
    remaining = total - pos;
    last_frag = 32'(remaining) <= 32'(lim);
    frag_len  = last_frag ? 11'(remaining) : lim;
    fu_ind    = (hdr_byte & NAL_FNRI_MASK) | {3'd0, FU_A_TYPE};
  end

  always_comb begin
    seq_next         = seq;
    timestamp_next   = timestamp;
    pos_next         = pos;
    total_next       = total;
    hdr_byte_next    = hdr_byte;
    fragmenting_next = fragmenting;
    lim_next         = lim;
    frag_left_next   = frag_left;
    frag_plen_next   = frag_plen;
    cmd_valid        = 1'b0;
    cmd              = '0;
    cmd.ts           = timestamp;
    cmd.data         = item.nal_byte;
    cmd.fu_ind       = fu_ind;
    cmd.seq          = seq + 16'd1;

    if (item.first_of_nal) begin
      timestamp_next   = timestamp + 32'(ts_step);
      total_next       = len_c;
      pos_next         = '0;
      fragmenting_next = 1'b0;
      cmd.ts           = timestamp_next;
      if (len_c != '0) begin
        cmd_valid     = 1'b1;
        lim_next      = lim_c;
        hdr_byte_next = item.nal_byte;
        pos_next      = POS_W'(1);
        seq_next      = seq + 16'd1;
        cmd.has_hdr   = 1'b1;
        cmd.fu_ind    = (item.nal_byte & NAL_FNRI_MASK) | {3'd0, FU_A_TYPE};
        if (32'(len_c) <= 32'(lim_c)) begin
          cmd.has_data = 1'b1;
          cmd.plen     = 11'(len_c) + RTP_HDR_BYTES;
          cmd.data_end = len_c == POS_W'(1);
        end else begin
          // first fragment: the NAL header byte itself is not payload
          fragmenting_next = 1'b1;
          cmd.has_fu       = 1'b1;
          cmd.plen         = FU_HDR_BYTES + lim_c - 11'd1;
          cmd.fu_hdr       = {1'b1, 2'b00, item.nal_byte[4:0]};
          frag_left_next   = lim_c - 11'd1;
          frag_plen_next   = cmd.plen;
        end
      end
    end else if (pos < total) begin
      cmd_valid    = 1'b1;
      cmd.has_data = 1'b1;
      pos_next     = pos_inc;
      if (!fragmenting) begin
        cmd.plen     = 11'(total) + RTP_HDR_BYTES;
        cmd.data_end = pos_inc == total;
      end else if (frag_left == 11'd0) begin
        seq_next       = seq + 16'd1;
        cmd.has_hdr    = 1'b1;
        cmd.has_fu     = 1'b1;
        cmd.marker     = last_frag;
        cmd.plen       = FU_HDR_BYTES + frag_len;
        cmd.fu_hdr     = {1'b0, last_frag, 1'b0, hdr_byte[4:0]};
        cmd.data_end   = frag_len == 11'd1;
        frag_left_next = frag_len - 11'd1;
        frag_plen_next = cmd.plen;
      end else begin
        cmd.plen       = frag_plen;
        cmd.data_end   = frag_left == 11'd1;
        frag_left_next = frag_left - 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq         <= '0;
      timestamp   <= '0;
      pos         <= '0;
      total       <= '0;
      hdr_byte    <= '0;
      fragmenting <= 1'b0;
      lim         <= PAYLOAD_LIMIT_RST;
      frag_left   <= '0;
      frag_plen   <= '0;
    end else if (take) begin
      seq         <= seq_next;
      timestamp   <= timestamp_next;
      pos         <= pos_next;
      total       <= total_next;
      hdr_byte    <= hdr_byte_next;
      fragmenting <= fragmenting_next;
      lim         <= lim_next;
      frag_left   <= frag_left_next;
      frag_plen   <= frag_plen_next;
    end
  end

endmodule

`default_nettype wire

### rtl/h264rtp_cmd_fifo.sv
`default_nettype none

module h264rtp_cmd_fifo (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire h264rtp_pkg::cmd_t push_cmd,
  input  wire logic              pop,
  output logic                   head_valid,
  output h264rtp_pkg::cmd_t      head,
  output logic                   full
);
  import h264rtp_pkg::*;

  localparam int PTR_W = $clog2(CMD_FIFO_DEPTH);
  localparam int CNT_W = $clog2(CMD_FIFO_DEPTH + 1);

  cmd_t             entries [CMD_FIFO_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head_valid = count != '0;
  assign full       = count == CNT_W'(CMD_FIFO_DEPTH);
  assign head       = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(CMD_FIFO_DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CNT_W'(1);
        2'b01:   count <= count - CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/h264rtp_back.sv
`default_nettype none

module h264rtp_back (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   head_valid,
  input  wire h264rtp_pkg::cmd_t      head,
  input  wire logic [6:0]             rtp_ptype,
  input  wire logic [31:0]            ssrc_value,
  input  wire logic                   pkt_stall,
  output logic                        pop,
  output logic                        pkt_valid,
  output h264rtp_pkg::pkt_item_t      pkt_item
);
  import h264rtp_pkg::*;

  localparam logic [3:0] SLOT_FIRST    = 4'd0;
  localparam logic [3:0] SLOT_HDR_LAST = 4'd11;
  localparam logic [3:0] SLOT_FU_IND   = 4'd12;
  localparam logic [3:0] SLOT_FU_HDR   = 4'd13;
  localparam logic [3:0] SLOT_DATA     = 4'd14;

  logic [3:0] slot;
  logic [3:0] cur;
  logic [3:0] slot_next;
  logic       cmd_done;
  logic       load;
  logic [7:0] byte_sel;

  assign load = head_valid && (!pkt_valid || !pkt_stall);
  assign cur  = (slot == SLOT_FIRST && !head.has_hdr) ? SLOT_DATA : slot;

  always_comb begin
    cmd_done  = 1'b0;
    slot_next = cur + 4'd1;
    if (cur == SLOT_HDR_LAST) begin
      slot_next = head.has_fu ? SLOT_FU_IND : SLOT_DATA;
    end else if (cur == SLOT_FU_HDR) begin
      cmd_done = !head.has_data;
    end else if (cur == SLOT_DATA) begin
      cmd_done = 1'b1;
    end
  end

  assign pop = load && cmd_done;

  always_comb begin
    case (cur)
      SLOT_FIRST:    byte_sel = RTP_BYTE0;
      4'd1:          byte_sel = {head.marker, rtp_ptype};
      4'd2:          byte_sel = head.seq[15:8];
      4'd3:          byte_sel = head.seq[7:0];
      4'd4:          byte_sel = head.ts[31:24];
      4'd5:          byte_sel = head.ts[23:16];
      4'd6:          byte_sel = head.ts[15:8];
      4'd7:          byte_sel = head.ts[7:0];
      4'd8:          byte_sel = ssrc_value[31:24];
      4'd9:          byte_sel = ssrc_value[23:16];
      4'd10:         byte_sel = ssrc_value[15:8];
      SLOT_HDR_LAST: byte_sel = ssrc_value[7:0];
      SLOT_FU_IND:   byte_sel = head.fu_ind;
      SLOT_FU_HDR:   byte_sel = head.fu_hdr;
      default:       byte_sel = head.data;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot      <= SLOT_FIRST;
      pkt_valid <= 1'b0;
    end else begin
      if (load) begin
        slot      <= cmd_done ? SLOT_FIRST : slot_next;
        pkt_valid <= 1'b1;
      end else if (!pkt_stall) begin
        pkt_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      pkt_item.out_byte      <= byte_sel;
      pkt_item.packet_start  <= cur == SLOT_FIRST;
      pkt_item.packet_end    <= cur == SLOT_DATA && head.data_end;
      pkt_item.packet_length <= head.plen;
    end
  end

endmodule

`default_nettype wire

### rtl/h264rtp_checker.sv
`default_nettype none

module h264rtp_checker (
  input wire logic                                clk,
  input wire logic                                rst,
  input wire logic                                nal_stall,
  input wire logic                                pkt_valid,
  input wire logic                                pkt_stall,
  input wire h264rtp_pkg::pkt_item_t              pkt_item,
  input wire logic                                cfg_wr_en,
  input wire logic [h264rtp_pkg::CFG_INDEX_W-1:0] cfg_index
);
  import h264rtp_pkg::*;

  a_pkt_hold: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_stall |=> pkt_valid && $stable(pkt_item))
    else $error("stalled packet transfer changed");

  a_start_byte: assert property (@(posedge clk) disable iff (rst)
    pkt_valid && pkt_item.packet_start |-> pkt_item.out_byte == RTP_BYTE0)
    else $error("packet does not open with the RTP version byte");

  a_start_not_end: assert property (@(posedge clk) disable iff (rst)
    pkt_valid |-> !(pkt_item.packet_start && pkt_item.packet_end))
    else $error("packet starts and ends on one byte");

  a_min_length: assert property (@(posedge clk) disable iff (rst)
    pkt_valid |-> pkt_item.packet_length >= 11'd13)
    else $error("packet length below header plus one byte");

  a_rate_write_stalls: assert property (@(posedge clk) disable iff (rst)
    cfg_wr_en && cfg_index == REG_FRAME_RATE |=> nal_stall)
    else $error("input not held off while timestamp step is recomputed");

endmodule

bind h264_nal_rtp_packetizer_core h264rtp_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .nal_stall (nal_stall),
  .pkt_valid (pkt_valid),
  .pkt_stall (pkt_stall),
  .pkt_item  (pkt_item),
  .cfg_wr_en (cfg_wr_en),
  .cfg_index (cfg_index)
);

`default_nettype wire
